// ===== rtl/core/okbd_pkg.sv =====
// okbd_pkg: shared types, rotation table and helper functions for the block decrypter
`default_nettype none

package okbd_pkg;

	localparam int unsigned NUM_WORDS = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [7:0] TABLE_XOR = 8'hA5;
	localparam logic [4:0] WORD_TABLE_SHIFT = 5'h0C;

	typedef logic [4:0] rot_t;

	// register indexes on the write port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_WORD_0 = 2'd0,
		REG_KEY_WORD_1 = 2'd1,
		REG_KEY_WORD_2 = 2'd2,
		REG_KEY_WORD_3 = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] block_offset;
		logic [63:0] cipher_low;
		logic [63:0] cipher_high;
	} okbd_in_t;

	typedef struct packed {
		logic [63:0] plain_low;
		logic [63:0] plain_high;
	} okbd_out_t;

	localparam logic [31:0][7:0] ROT_TABLE = {
		8'hB9, 8'hB1, 8'hA9, 8'hA1, 8'hBA, 8'hBB, 8'hB8, 8'hB9,
		8'hBE, 8'hBF, 8'hBC, 8'hB2, 8'hB3, 8'hB0, 8'hB1, 8'hB6,
		8'hB7, 8'hB4, 8'hAA, 8'hAB, 8'hA8, 8'hA9, 8'hAE, 8'hAF,
		8'hAC, 8'hA2, 8'hA3, 8'hA0, 8'hA1, 8'hA6, 8'hA7, 8'hA4
	};

	function automatic rot_t rot_amount(input logic [4:0] idx);
		logic [7:0] v;
		v = ROT_TABLE[idx] ^ TABLE_XOR;
		return v[4:0];
	endfunction

	function automatic logic [31:0] rotr32(input logic [31:0] v, input rot_t n);
		logic [63:0] t;
		t = {v, v} >> n;
		return t[31:0];
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input rot_t n);
		logic [63:0] t;
		t = {v, v} << n;
		return t[63:32];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/offset_keyed_block_decrypt.sv =====
// offset_keyed_block_decrypt: three-stage pipelined 16-byte block decrypter
//
// Input channel in_valid/in_ready carries one block with its archive byte
// offset; output channel out_valid/out_ready carries the decrypted block.
// A transfer happens at a clock edge where valid and ready are both high.
// The four key words are written through wr_en/wr_index/wr_data, one word
// per cycle, and should only change while no block is in flight.
// Pipeline: stage 1 applies the offset byte mix and looks up the eight
// rotation amounts, stage 2 rotates the key words and mixes them in,
// stage 3 rotates each word and holds the result for the receiver.
// One block is taken per cycle for as long as the receiver keeps out_ready
// high. When the receiver stalls, stages fill up from the output side and
// in_ready drops only once all three stages hold a block; nothing is lost
// or repeated. Reset empties the pipeline and clears the key words to zero.
`default_nettype none

module offset_keyed_block_decrypt (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire okbd_pkg::okbd_in_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output okbd_pkg::okbd_out_t                    out_data,
	input  wire logic                              wr_en,
	input  wire logic [okbd_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [okbd_pkg::CFG_DATA_W-1:0]   wr_data
);
	import okbd_pkg::*;

	logic [NUM_WORDS-1:0][31:0] key_q;

	logic                       v_s1, v_s2, v_s3;
	logic [NUM_WORDS-1:0][31:0] word_s1, word_s2, word_s3;
	rot_t [NUM_WORDS-1:0]       krot_s1;
	rot_t [NUM_WORDS-1:0]       wrot_s1, wrot_s2;

	logic adv1, adv2, adv3;

	// a stage moves on when it is empty or the one after it moves on
	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_KEY_WORD_0: key_q[0] <= wr_data;
				REG_KEY_WORD_1: key_q[1] <= wr_data;
				REG_KEY_WORD_2: key_q[2] <= wr_data;
				REG_KEY_WORD_3: key_q[3] <= wr_data;
				default: ;
			endcase
		end
	end

	// stage 1 logic: byte mix and table lookups
	logic [15:0][7:0]           blk_in;
	logic [15:0][7:0]           blk_mix;
	logic [7:0]                 xk;
	logic [3:0]                 sel;
	logic [4:0]                 tidx;
	rot_t [NUM_WORDS-1:0]       krot_d, wrot_d;

	always_comb begin
		blk_in = {in_data.cipher_high, in_data.cipher_low};
		sel    = in_data.block_offset[3:0];
		tidx   = in_data.block_offset[8:4];
		xk     = blk_in[sel];
		for (int i = 0; i < 16; i++) begin
			blk_mix[i] = (4'(i) == sel) ? blk_in[i] : (blk_in[i] ^ xk);
		end
		for (int i = 0; i < NUM_WORDS; i++) begin
			krot_d[i] = rot_amount(5'(tidx + 5'(3 * i)));
			wrot_d[i] = rot_amount(5'(tidx + WORD_TABLE_SHIFT + 5'(3 * i)));
		end
	end

	// stage 2 logic: rotated key mixed into each word
	logic [NUM_WORDS-1:0][31:0] keyed_d;

	always_comb begin
		for (int i = 0; i < NUM_WORDS; i++) begin
			if (i % 2 == 0) begin
				keyed_d[i] = word_s1[i] ^ rotr32(key_q[i], krot_s1[i]);
			end else begin
				keyed_d[i] = word_s1[i] ^ rotl32(key_q[i], krot_s1[i]);
			end
		end
	end

	// stage 3 logic: final word rotation
	logic [NUM_WORDS-1:0][31:0] rot_d;

	always_comb begin
		for (int i = 0; i < NUM_WORDS; i++) begin
			if (i % 2 == 0) begin
				rot_d[i] = rotr32(word_s2[i], wrot_s2[i]);
			end else begin
				rot_d[i] = rotl32(word_s2[i], wrot_s2[i]);
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			word_s1 <= blk_mix;
			krot_s1 <= krot_d;
			wrot_s1 <= wrot_d;
		end
		if (adv2 && v_s1) begin
			word_s2 <= keyed_d;
			wrot_s2 <= wrot_s1;
		end
		if (adv3 && v_s2) begin
			word_s3 <= rot_d;
		end
	end

	assign out_valid           = v_s3;
	assign out_data.plain_low  = {word_s3[1], word_s3[0]};
	assign out_data.plain_high = {word_s3[3], word_s3[2]};

	a_in_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted block did not reach stage 1");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !adv3) |=> (v_s2 && $stable(word_s2) && $stable(wrot_s2)))
		else $error("stage 2 changed while stalled");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && !out_ready) |-> !in_ready)
		else $error("input taken while pipeline full and stalled");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv2) |=> v_s2)
		else $error("stage 1 block lost on advance");

endmodule

`default_nettype wire
